FILE: design/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset
`define ASSERT_NEXT_NR(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/e2c_pkg.sv
// Shared types, constants and tables for the equirect-to-cubemap address core
package e2c_pkg;

  localparam int MAX_WIDTH_DEF    = 8192;
  localparam int MAX_HEIGHT_DEF   = 4096;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int FACE_W  = 3;
  localparam int COORD_W = 11;
  localparam int SRCW_W  = 14;
  localparam int SRCH_W  = 13;
  localparam int CHAN_W  = 3;
  localparam int SRCX_W  = 13;
  localparam int SRCY_W  = 12;
  localparam int SIDX_W  = 27;
  localparam int DIDX_W  = 24;

  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

  localparam logic [SRCW_W-1:0] SRC_WIDTH_RST  = 14'd2048;
  localparam logic [SRCH_W-1:0] SRC_HEIGHT_RST = 13'd1024;
  localparam logic [CHAN_W-1:0] CHANNELS_RST   = 3'd4;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  // Q2.16 direction vectors, Q16 radian angles
  localparam int Q_FRAC    = 16;
  localparam int Q_ONE     = 65536;
  localparam int VEC_W     = 19;
  localparam int CORD_W    = 21;
  localparam int ANG_W     = 20;
  localparam int ATAN_W    = 17;
  localparam int PI_Q      = 205887;
  localparam int HALF_PI_Q = 102944;
  localparam int TWO_PI_Q  = 411774;
  localparam int THETA_W   = 19;
  localparam int PHI_W     = 18;

  // 2*col*2^16/fm1 is at most 2^17
  localparam int UDIV_Q_W = Q_FRAC + 2;

  // sqrt of x*x + z*z, sum below 2^34
  localparam int RAD_IN_W  = 34;
  localparam int RAD_STEPS = 17;
  localparam int RAD_W     = 17;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [SRCX_W-1:0] src_x;
    logic [SRCY_W-1:0] src_y;
    logic [SIDX_W-1:0] src_index;
    logic [DIDX_W-1:0] dst_index;
  } out_t;

  function automatic logic [ATAN_W-1:0] atan_q(input int k);
    logic [ATAN_W-1:0] v;
    case (k)
      0:  v = 17'd51472;
      1:  v = 17'd30386;
      2:  v = 17'd16055;
      3:  v = 17'd8150;
      4:  v = 17'd4091;
      5:  v = 17'd2047;
      6:  v = 17'd1024;
      7:  v = 17'd512;
      8:  v = 17'd256;
      9:  v = 17'd128;
      10: v = 17'd64;
      11: v = 17'd32;
      12: v = 17'd16;
      13: v = 17'd8;
      14: v = 17'd4;
      15: v = 17'd2;
      16: v = 17'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/e2c_dly.sv
// Enabled delay line for sideband data that rides along the pipeline
module e2c_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

FILE: design/e2c_ldiv.sv
// Pipelined restoring divider, one quotient bit per stage
module e2c_ldiv #(
  parameter int QW = 18,
  parameter int DW = 11
) (
  input  logic             clk,
  input  logic             en,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] low_nxt;
    logic [QW-1:0] q_nxt;

    // quotient fits QW bits, so the top slice starts below the divisor
    if (k == 0) begin : g_first
      assign rem_in = num[QW+DW-1:QW];
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial   = {rem_in, low_in[QW-1]};
    assign take    = trial >= {1'b0, den};
    assign rem_nxt = take ? DW'(trial - {1'b0, den}) : DW'(trial);
    assign low_nxt = low_in << 1;
    assign q_nxt   = {q_in[QW-2:0], take};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

FILE: design/e2c_cordic.sv
// Pipelined vectoring CORDIC: atan2(yi, xi) in Q16 radians
module e2c_cordic #(
  parameter int STEPS = e2c_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2c_pkg::VEC_W-1:0]  xi,
  input  logic signed [e2c_pkg::VEC_W-1:0]  yi,
  output logic signed [e2c_pkg::ANG_W-1:0]  ang
);

  localparam int CW = e2c_pkg::CORD_W;
  localparam int AW = e2c_pkg::ANG_W;
  localparam logic signed [AW-1:0] HALF_PI = AW'(e2c_pkg::HALF_PI_Q);

  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [AW-1:0] a_r [STEPS+1];
  logic                 zero_r [STEPS+1];

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] a_nxt;
  logic                 zero_nxt;

  assign xe       = CW'(xi);
  assign ye       = CW'(yi);
  assign zero_nxt = (xi == '0) && (yi == '0);

  // quarter turn into the right half plane
  always_comb begin
    if (xi < 0) begin
      if (yi >= 0) begin
        x_nxt = ye;
        y_nxt = -xe;
        a_nxt = HALF_PI;
      end else begin
        x_nxt = -ye;
        y_nxt = xe;
        a_nxt = -HALF_PI;
      end
    end else begin
      x_nxt = xe;
      y_nxt = ye;
      a_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt;
      y_r[0]    <= y_nxt;
      a_r[0]    <= a_nxt;
      zero_r[0] <= zero_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] at_k;
    logic signed [CW-1:0] xs_nxt, ys_nxt;
    logic signed [AW-1:0] as_nxt;

    assign dx   = x_r[k] >>> k;
    assign dy   = y_r[k] >>> k;
    assign at_k = AW'(e2c_pkg::atan_q(k));

    always_comb begin
      if (y_r[k] > 0) begin
        xs_nxt = x_r[k] + dy;
        ys_nxt = y_r[k] - dx;
        as_nxt = a_r[k] + at_k;
      end else begin
        xs_nxt = x_r[k] - dy;
        ys_nxt = y_r[k] + dx;
        as_nxt = a_r[k] - at_k;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]    <= xs_nxt;
        y_r[k+1]    <= ys_nxt;
        a_r[k+1]    <= as_nxt;
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  // zero vector reads as angle zero
  assign ang = zero_r[STEPS] ? '0 : a_r[STEPS];

endmodule

FILE: design/e2c_radius.sv
// Pipelined floor(sqrt(x*x + z*z)): square, sum, then one root bit per stage
module e2c_radius (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2c_pkg::VEC_W-1:0]  xi,
  input  logic signed [e2c_pkg::VEC_W-1:0]  zi,
  output logic        [e2c_pkg::RAD_W-1:0]  r
);

  localparam int NW = e2c_pkg::RAD_IN_W;
  localparam int SW = NW - 1;
  localparam int NS = e2c_pkg::RAD_STEPS;
  localparam int PW = 2 * e2c_pkg::VEC_W;

  logic signed [PW-1:0] sqx, sqz;
  logic [SW-1:0] xsq_r, zsq_r;
  logic [NW-1:0] sum_r;
  logic [NW-1:0] nn_r [NS];
  logic [NW-1:0] rr_r [NS];

  assign sqx = xi * xi;
  assign sqz = zi * zi;

  always_ff @(posedge clk) begin
    if (en) begin
      xsq_r <= SW'(sqx);
      zsq_r <= SW'(sqz);
      sum_r <= {1'b0, xsq_r} + {1'b0, zsq_r};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (NS - 1 - k));
    logic [NW-1:0] nn_in, rr_in;
    logic [NW:0]   trial;
    logic          take;
    logic [NW-1:0] nn_nxt, rr_nxt;

    if (k == 0) begin : g_first
      assign nn_in = sum_r;
      assign rr_in = '0;
    end else begin : g_next
      assign nn_in = nn_r[k-1];
      assign rr_in = rr_r[k-1];
    end

    assign trial  = {1'b0, rr_in} + {1'b0, BIT};
    assign take   = {1'b0, nn_in} >= trial;
    assign nn_nxt = take ? NW'({1'b0, nn_in} - trial) : nn_in;
    assign rr_nxt = take ? (rr_in >> 1) + BIT : rr_in >> 1;

    always_ff @(posedge clk) begin
      if (en) begin
        nn_r[k] <= nn_nxt;
        rr_r[k] <= rr_nxt;
      end
    end
  end

  assign r = e2c_pkg::RAD_W'(rr_r[NS-1]);

endmodule

FILE: design/equirect_to_cubemap_address_core.sv
// Equirect-to-cubemap address core: takes one cube-face pixel per clock and
// returns the equirectangular source pixel (rounded down) plus source and face
// byte offsets. The pipeline depth comes from the 18-bit u/v divider, the
// 17-step square root and the phi CORDIC, all one step per stage, plus a
// two-stage reciprocal multiply that turns the angles into pixels. A new pixel
// is taken every cycle; the whole pipeline holds while a result beat waits at
// the output.
module equirect_to_cubemap_address_core #(
  parameter int MAX_WIDTH    = e2c_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = e2c_pkg::MAX_HEIGHT_DEF,
  parameter int CORDIC_STEPS = e2c_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  e2c_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output e2c_pkg::out_t                     out_data,
  input  logic                              cfg_wr_en,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [e2c_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int QX   = $clog2(MAX_WIDTH);
  localparam int QY   = $clog2(MAX_HEIGHT);
  localparam int QS   = (QX > QY) ? QX : QY;
  localparam int FMW  = $clog2(MAX_HEIGHT / 2);
  localparam int FSW  = $clog2(MAX_HEIGHT / 2 + 1);
  localparam int CRW  = e2c_pkg::COORD_W;
  localparam int VW   = e2c_pkg::VEC_W;
  localparam int AW   = e2c_pkg::ANG_W;
  localparam int DQW  = e2c_pkg::UDIV_Q_W;
  localparam int DNW  = DQW + FMW;
  localparam int TW   = e2c_pkg::THETA_W;
  localparam int PW   = e2c_pkg::PHI_W;
  localparam int XNW  = QS + TW;
  localparam int YNW  = QS + PW;
  localparam int RDLY = 2 + e2c_pkg::RAD_STEPS;
  localparam int RC_DLY = DQW + 1 + RDLY + 1 + CORDIC_STEPS + 1 + 2;
  localparam int LAT  = 1 + DQW + 1 + RDLY + 1 + CORDIC_STEPS + 1 + 2 + 2;
  localparam int M1W  = QS + WW;
  localparam int M2W  = CRW + FSW;
  localparam int SSW  = M1W + 1;
  localparam int DSW  = M2W + 1;
  localparam int SPW  = SSW + e2c_pkg::CHAN_W;
  localparam int DPW  = DSW + e2c_pkg::CHAN_W;

  // exact floor division by 2*PI and PI: multiply by ceil(2^s/d), s wide
  // enough that the rounding error never reaches the next integer
  localparam int SX   = XNW + TW;
  localparam int SY   = YNW + PW;
  localparam int RXW  = XNW + 1;
  localparam int RYW  = YNW + 1;
  localparam int RLW  = 17;
  localparam logic [63:0] RCP_X = ((64'd1 << SX) + 64'(e2c_pkg::TWO_PI_Q) - 64'd1) /
                                  64'(e2c_pkg::TWO_PI_Q);
  localparam logic [63:0] RCP_Y = ((64'd1 << SY) + 64'(e2c_pkg::PI_Q) - 64'd1) /
                                  64'(e2c_pkg::PI_Q);
  localparam logic [RLW-1:0]     RCP_X_LO = RCP_X[RLW-1:0];
  localparam logic [RXW-RLW-1:0] RCP_X_HI = RCP_X[RXW-1:RLW];
  localparam logic [RLW-1:0]     RCP_Y_LO = RCP_Y[RLW-1:0];
  localparam logic [RYW-RLW-1:0] RCP_Y_HI = RCP_Y[RYW-1:RLW];

  localparam logic signed [VW-1:0]   Q1      = VW'(e2c_pkg::Q_ONE);
  localparam logic signed [AW:0]     PI_S    = (AW+1)'(e2c_pkg::PI_Q);
  localparam logic signed [AW:0]     TWO_PI_S = (AW+1)'(e2c_pkg::TWO_PI_Q);
  localparam logic signed [AW-1:0]   PHI_MAX = AW'(e2c_pkg::PI_Q);

  // ---------------- configuration ----------------
  logic [e2c_pkg::SRCW_W-1:0] cfg_w_r;
  logic [e2c_pkg::SRCH_W-1:0] cfg_h_r;
  logic [e2c_pkg::CHAN_W-1:0] cfg_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= e2c_pkg::SRC_WIDTH_RST;
      cfg_h_r  <= e2c_pkg::SRC_HEIGHT_RST;
      cfg_ch_r <= e2c_pkg::CHANNELS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        e2c_pkg::CFG_SRC_WIDTH:  cfg_w_r  <= cfg_data[e2c_pkg::SRCW_W-1:0];
        e2c_pkg::CFG_SRC_HEIGHT: cfg_h_r  <= cfg_data[e2c_pkg::SRCH_W-1:0];
        e2c_pkg::CFG_CHANNELS:   cfg_ch_r <= cfg_data[e2c_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [FSW-1:0] fs;
  logic [FMW-1:0] fm1;
  logic [QX-1:0]  wm1;
  logic [QY-1:0]  hm1;

  assign w_eff = (32'(cfg_w_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_r);
  assign h_eff = (32'(cfg_h_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h_r);
  assign fs    = FSW'(h_eff >> 1);
  assign fm1   = (fs != '0) ? FMW'(fs - 1'b1) : '0;
  assign wm1   = (w_eff != '0) ? QX'(w_eff - 1'b1) : '0;
  assign hm1   = (h_eff != '0) ? QY'(h_eff - 1'b1) : '0;

  // ---------------- flow control ----------------
  logic           adv;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- input stage: clamp to face ----------------
  logic [e2c_pkg::FACE_W-1:0] face_r;
  logic [CRW-1:0]             col_r, row_r;
  logic [CRW-1:0]             col_nxt, row_nxt;

  assign col_nxt = (32'(in_data.col) > 32'(fm1)) ? CRW'(fm1) : in_data.col;
  assign row_nxt = (32'(in_data.row) > 32'(fm1)) ? CRW'(fm1) : in_data.row;

  always_ff @(posedge clk) begin
    if (adv) begin
      face_r <= in_data.face;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  // ---------------- u, v = 2*c*2^16/fm1 - 2^16 ----------------
  logic [DNW-1:0] u_num, v_num;
  logic [DQW-1:0] u_q, v_q;

  assign u_num = DNW'(col_r) << (e2c_pkg::Q_FRAC + 1);
  assign v_num = DNW'(row_r) << (e2c_pkg::Q_FRAC + 1);

  e2c_ldiv #(.QW(DQW), .DW(FMW)) u_udiv (
    .clk(clk), .en(adv), .num(u_num), .den(fm1), .quo(u_q)
  );

  e2c_ldiv #(.QW(DQW), .DW(FMW)) u_vdiv (
    .clk(clk), .en(adv), .num(v_num), .den(fm1), .quo(v_q)
  );

  logic [e2c_pkg::FACE_W-1:0] face_d;
  logic [2*CRW-1:0]           rc_d;

  e2c_dly #(.W(e2c_pkg::FACE_W), .N(DQW)) u_face_dly (
    .clk(clk), .en(adv), .d(face_r), .q(face_d)
  );

  e2c_dly #(.W(2*CRW), .N(RC_DLY)) u_rc_dly (
    .clk(clk), .en(adv), .d({col_r, row_r}), .q(rc_d)
  );

  // ---------------- face direction ----------------
  logic signed [VW-1:0] u_val, v_val;
  logic signed [VW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [VW-1:0] x_r, y_r, z_r;

  // face size of one or less gives the face center
  assign u_val = (fm1 == '0) ? '0 : $signed({1'b0, u_q}) - Q1;
  assign v_val = (fm1 == '0) ? '0 : $signed({1'b0, v_q}) - Q1;

  always_comb begin
    case (face_d)
      e2c_pkg::FACE_NEG_X: begin
        x_nxt = -Q1;    y_nxt = -v_val; z_nxt = u_val;
      end
      e2c_pkg::FACE_POS_Y: begin
        x_nxt = u_val;  y_nxt = Q1;     z_nxt = -v_val;
      end
      e2c_pkg::FACE_NEG_Y: begin
        x_nxt = u_val;  y_nxt = -Q1;    z_nxt = v_val;
      end
      e2c_pkg::FACE_POS_Z: begin
        x_nxt = u_val;  y_nxt = -v_val; z_nxt = Q1;
      end
      e2c_pkg::FACE_NEG_Z: begin
        x_nxt = -u_val; y_nxt = -v_val; z_nxt = -Q1;
      end
      default: begin
        x_nxt = Q1;     y_nxt = -v_val; z_nxt = -u_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // ---------------- angles ----------------
  logic signed [AW-1:0]            theta, theta_d, phi;
  logic [AW-1:0]                   theta_dq;
  logic [e2c_pkg::RAD_W-1:0]       rad;
  logic [VW-1:0]                   y_dq;
  logic signed [VW-1:0]            y_d, rad_s;

  e2c_cordic #(.STEPS(CORDIC_STEPS)) u_theta (
    .clk(clk), .en(adv), .xi(x_r), .yi(z_r), .ang(theta)
  );

  e2c_dly #(.W(AW), .N(RDLY)) u_theta_dly (
    .clk(clk), .en(adv), .d(theta), .q(theta_dq)
  );

  e2c_radius u_radius (
    .clk(clk), .en(adv), .xi(x_r), .zi(z_r), .r(rad)
  );

  e2c_dly #(.W(VW), .N(RDLY)) u_y_dly (
    .clk(clk), .en(adv), .d(y_r), .q(y_dq)
  );

  assign theta_d = $signed(theta_dq);
  assign y_d     = $signed(y_dq);
  assign rad_s   = $signed(VW'(rad));

  e2c_cordic #(.STEPS(CORDIC_STEPS)) u_phi (
    .clk(clk), .en(adv), .xi(y_d), .yi(rad_s), .ang(phi)
  );

  // ---------------- angle to pixel ----------------
  logic signed [AW:0] tt;
  logic [TW-1:0]      tcl;
  logic [PW-1:0]      pcl;
  logic [XNW-1:0]     xn_r, xn_nxt;
  logic [YNW-1:0]     yn_r, yn_nxt;

  assign tt  = (AW+1)'(theta_d) + PI_S;
  assign tcl = (tt < 0) ? '0 : (tt > TWO_PI_S) ? TW'(TWO_PI_S) : TW'(tt);
  assign pcl = (phi < 0) ? '0 : (phi > PHI_MAX) ? PW'(PHI_MAX) : PW'(phi);
  assign xn_nxt = XNW'(tcl) * XNW'(wm1);
  assign yn_nxt = YNW'(pcl) * YNW'(hm1);

  always_ff @(posedge clk) begin
    if (adv) begin
      xn_r <= xn_nxt;
      yn_r <= yn_nxt;
    end
  end

  // split the reciprocal in two partial products, then add and shift
  logic [XNW+RLW-1:0]     xlo_r;
  logic [XNW+RXW-RLW-1:0] xhi_r;
  logic [YNW+RLW-1:0]     ylo_r;
  logic [YNW+RYW-RLW-1:0] yhi_r;
  logic [XNW+RXW-1:0]     xprod;
  logic [YNW+RYW-1:0]     yprod;
  logic [QS-1:0]          px_nxt, py_nxt;
  logic [QS-1:0]          px_r, py_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xlo_r <= (XNW+RLW)'(xn_r) * (XNW+RLW)'(RCP_X_LO);
      xhi_r <= (XNW+RXW-RLW)'(xn_r) * (XNW+RXW-RLW)'(RCP_X_HI);
      ylo_r <= (YNW+RLW)'(yn_r) * (YNW+RLW)'(RCP_Y_LO);
      yhi_r <= (YNW+RYW-RLW)'(yn_r) * (YNW+RYW-RLW)'(RCP_Y_HI);
    end
  end

  assign xprod  = {xhi_r, {RLW{1'b0}}} + (XNW+RXW)'(xlo_r);
  assign yprod  = {yhi_r, {RLW{1'b0}}} + (YNW+RYW)'(ylo_r);
  assign px_nxt = QS'(xprod >> SX);
  assign py_nxt = QS'(yprod >> SY);

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  // ---------------- byte offsets ----------------
  logic [CRW-1:0] col_d, row_d;
  logic [M1W-1:0] m1_r;
  logic [M2W-1:0] m2_r;
  logic [QS-1:0]  px1_r, py1_r;
  logic [CRW-1:0] col1_r;

  assign col_d = rc_d[2*CRW-1:CRW];
  assign row_d = rc_d[CRW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= M1W'(py_r) * M1W'(w_eff);
      m2_r   <= M2W'(row_d) * M2W'(fs);
      px1_r  <= px_r;
      py1_r  <= py_r;
      col1_r <= col_d;
    end
  end

  logic [SSW-1:0]      s_sum;
  logic [DSW-1:0]      d_sum;
  logic [SPW-1:0]      s_prod;
  logic [DPW-1:0]      d_prod;
  e2c_pkg::out_t       out_r, out_nxt;

  assign s_sum  = SSW'(m1_r) + SSW'(px1_r);
  assign d_sum  = DSW'(m2_r) + DSW'(col1_r);
  assign s_prod = SPW'(s_sum) * SPW'(cfg_ch_r);
  assign d_prod = DPW'(d_sum) * DPW'(cfg_ch_r);

  always_comb begin
    out_nxt.src_x     = e2c_pkg::SRCX_W'(px1_r);
    out_nxt.src_y     = e2c_pkg::SRCY_W'(py1_r);
    out_nxt.src_index = e2c_pkg::SIDX_W'(s_prod);
    out_nxt.dst_index = e2c_pkg::DIDX_W'(d_prod);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[LAT-1];

endmodule

FILE: design/e2c_chk.sv
// Port-level checker for the equirect-to-cubemap address core, with bind
`include "assert_macros.svh"

module e2c_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input e2c_pkg::out_t out_data
);

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // input side moves exactly when the output slot frees
  `ASSERT_IMPLIES(a_ready_flow, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))

  // reset drains the pipeline
  `ASSERT_NEXT_NR(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind equirect_to_cubemap_address_core e2c_chk u_e2c_chk (.*);
